FILE: rtl/pulse_width_servo_position_control_defines.svh
// ----------------------------------------------------------------------------
// Servo position controller assertion macros
// Shared concurrent-assertion forms used by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_SERVO_POSITION_CONTROL_DEFINES_SVH
`define PULSE_WIDTH_SERVO_POSITION_CONTROL_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PWSP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pwsp assertion failed");

// Next-cycle implication, checked out of reset.
`define PWSP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pwsp assertion failed");

`endif

FILE: rtl/pwsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo position controller package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pwsp_pkg;

    localparam int WINDOW_LEN_DEF = 128;
    localparam int ADC_BITS_DEF   = 12;

    localparam int TARGET_W = 13;
    localparam int WIDTH_W  = 16;
    localparam int TOL_W    = 12;
    localparam int DIV_W    = 16;
    localparam int STEP_W   = 5;
    localparam int FS_LOG2  = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [TARGET_W-1:0] FULL_SCALE = 13'd4096;

    localparam logic [TOL_W-1:0]   TOL_RESET  = 12'd10;
    localparam logic [WIDTH_W-1:0] MAXP_RESET = 16'd2000;
    localparam logic [WIDTH_W-1:0] SINT_RESET = 16'd10;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INT = 2'd2;

    localparam logic [1:0] DRIVE_BRAKE = 2'd0;
    localparam logic [1:0] DRIVE_CW    = 2'd1;
    localparam logic [1:0] DRIVE_CCW   = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       div_start;
        logic       div_cap;
        logic       tgt_direct;
        logic       ring_rd;
        logic       ring_wr;
        logic       avg_load;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic pulse_end;
        logic sample_due;
        logic tgt_direct;
        logic div_busy;
    } t_stat;

endpackage

FILE: rtl/pwsp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo position controller serial divider
// Restoring long division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwsp_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pwsp_pkg::DIV_W-1:0]     i_divisor,
    input  logic [pwsp_pkg::DIV_W-1:0]     i_rem,
    input  logic [pwsp_pkg::DIV_W-1:0]     i_low,
    input  logic [pwsp_pkg::STEP_W-1:0]    i_steps,
    output logic                           o_busy,
    output logic [pwsp_pkg::DIV_W-1:0]     o_quot
);

    localparam int DW = pwsp_pkg::DIV_W;

    logic [pwsp_pkg::STEP_W-1:0] r_cnt;
    logic [DW-1:0]               r_rem;
    logic [DW-1:0]               r_low;
    logic [DW-1:0]               r_quot;
    logic [DW-1:0]               r_dvs;
    logic [DW:0]                 trial;
    logic [DW:0]                 trial_sub;
    logic                        fits;

    // remainder stays below the divisor, so one extra bit covers the trial
    assign trial     = {r_rem, r_low[DW-1]};
    assign trial_sub = trial - {1'b0, r_dvs};
    assign fits      = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem;
            r_low  <= i_low;
            r_dvs  <= i_divisor;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= fits ? trial_sub[DW-1:0] : trial[DW-1:0];
            r_low  <= {r_low[DW-2:0], 1'b0};
            r_quot <= {r_quot[DW-2:0], fits};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

FILE: rtl/pwsp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo position controller datapath
// Pulse timer, sample rings and sums, divider, drive decision, output regs.
// ----------------------------------------------------------------------------
module pwsp_dp #(
    parameter int WINDOW_LEN = pwsp_pkg::WINDOW_LEN_DEF,
    parameter int ADC_BITS   = pwsp_pkg::ADC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pwsp_pkg::t_cmd                      i_cmd,
    output pwsp_pkg::t_stat                     o_stat,
    input  logic                                i_pulse_level,
    input  logic [ADC_BITS-1:0]                 i_adc_sample,
    input  logic                                i_cfg_we,
    input  logic [pwsp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pwsp_pkg::WIDTH_W-1:0]        i_cfg_data,
    output logic [1:0]                          o_drive,
    output logic [pwsp_pkg::TARGET_W-1:0]       o_target_average,
    output logic [ADC_BITS-1:0]                 o_position_average,
    output logic [pwsp_pkg::WIDTH_W-1:0]        o_measured_width
);

    localparam int TW     = pwsp_pkg::TARGET_W;
    localparam int WW     = pwsp_pkg::WIDTH_W;
    localparam int DW     = pwsp_pkg::DIV_W;
    localparam int IDX_W  = $clog2(WINDOW_LEN);
    localparam int TSUM_W = TW + IDX_W;
    localparam int PSUM_W = ADC_BITS + IDX_W;
    localparam int DIFF_W = ((ADC_BITS > TW) ? ADC_BITS : TW) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);

    // sum / WINDOW_LEN as a multiply by a rounded-up reciprocal, exact over the sum range
    localparam int TSH     = TSUM_W + IDX_W;
    localparam int PSH     = PSUM_W + IDX_W;
    localparam int TPROD_W = 2 * TSUM_W + 1;
    localparam int PPROD_W = 2 * PSUM_W + 1;
    localparam longint TRECIP = ((longint'(1) << TSH) + longint'(WINDOW_LEN) - 1)
                                / longint'(WINDOW_LEN);
    localparam longint PRECIP = ((longint'(1) << PSH) + longint'(WINDOW_LEN) - 1)
                                / longint'(WINDOW_LEN);

    // configuration
    logic [pwsp_pkg::TOL_W-1:0] r_tol;
    logic [WW-1:0]              r_maxp;
    logic [WW-1:0]              r_sint;

    // pulse timing and sampling
    logic                r_prev;
    logic                r_active;
    logic [WW-1:0]       r_count;
    logic [WW-1:0]       r_last_w;
    logic [WW-1:0]       r_w;
    logic                r_pulse_end;
    logic [WW-1:0]       r_timer;
    logic                r_sample;
    logic [ADC_BITS-1:0] r_adc;
    logic [WW-1:0]       clamp_w;
    logic [WW:0]         timer_inc;

    // window
    logic [TW-1:0]       r_target;
    logic [IDX_W-1:0]    r_k;
    logic                r_wrapped;
    logic [TW-1:0]       r_tring [WINDOW_LEN];
    logic [ADC_BITS-1:0] r_pring [WINDOW_LEN];
    logic [TW-1:0]       r_t_old;
    logic [ADC_BITS-1:0] r_p_old;
    logic [TW-1:0]       t_old;
    logic [ADC_BITS-1:0] p_old;
    logic [TSUM_W-1:0]   r_tsum;
    logic [PSUM_W-1:0]   r_psum;
    logic [TPROD_W-1:0]  tprod;
    logic [PPROD_W-1:0]  pprod;
    logic [TW-1:0]       r_tavg;
    logic [ADC_BITS-1:0] r_pavg;

    // divider
    logic                        div_busy;
    logic [DW-1:0]               div_quot;

    // drive
    logic                r_deadband;
    logic [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]   mag;
    logic [DIFF_W-1:0]   tol_now;
    logic [1:0]          drive_now;
    logic [1:0]          r_drive;
    logic [TW-1:0]       r_out_tavg;
    logic [ADC_BITS-1:0] r_out_pavg;
    logic [WW-1:0]       r_out_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= pwsp_pkg::TOL_RESET;
            r_maxp <= pwsp_pkg::MAXP_RESET;
            r_sint <= pwsp_pkg::SINT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pwsp_pkg::REG_TOLERANCE:  r_tol  <= i_cfg_data[pwsp_pkg::TOL_W-1:0];
                pwsp_pkg::REG_MAX_PULSE:  r_maxp <= i_cfg_data;
                pwsp_pkg::REG_SAMPLE_INT: r_sint <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign clamp_w   = (r_count > r_maxp) ? r_maxp : r_count;
    assign timer_inc = {1'b0, r_timer} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= 1'b0;
            r_active    <= 1'b0;
            r_count     <= '0;
            r_last_w    <= '0;
            r_timer     <= '0;
            r_pulse_end <= 1'b0;
            r_sample    <= 1'b0;
        end else if (i_cmd.accept) begin
            r_prev      <= i_pulse_level;
            r_pulse_end <= 1'b0;
            if (i_pulse_level && !r_prev && !r_active) begin
                r_active <= 1'b1;
                r_count  <= WW'(1);
            end else if (i_pulse_level && r_active) begin
                if (r_count != {WW{1'b1}}) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (!i_pulse_level && r_active) begin
                r_last_w    <= clamp_w;
                r_active    <= 1'b0;
                r_pulse_end <= 1'b1;
            end
            if (timer_inc >= {1'b0, r_sint}) begin
                r_timer  <= '0;
                r_sample <= 1'b1;
            end else begin
                r_timer  <= timer_inc[WW-1:0];
                r_sample <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_adc <= i_adc_sample;
            r_w   <= clamp_w;
        end
    end

    // width*4096/max_pulse_ticks: width below max_pulse_ticks, 12 quotient bits
    pwsp_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_divisor (r_maxp),
        .i_rem     (r_w),
        .i_low     ('0),
        .i_steps   (pwsp_pkg::STEP_W'(pwsp_pkg::FS_LOG2)),
        .o_busy    (div_busy),
        .o_quot    (div_quot)
    );

    // the rings fill in index order, so an entry is written once the index has wrapped
    assign t_old = r_wrapped ? r_t_old : '0;
    assign p_old = r_wrapped ? r_p_old : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ring_rd) begin
            r_t_old <= r_tring[r_k];
            r_p_old <= r_pring[r_k];
        end
        if (i_cmd.ring_wr) begin
            r_tring[r_k] <= r_target;
            r_pring[r_k] <= r_adc;
        end
    end

    assign tprod = TPROD_W'(r_tsum) * TPROD_W'(TRECIP);
    assign pprod = PPROD_W'(r_psum) * PPROD_W'(PRECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_k       <= '0;
            r_wrapped <= 1'b0;
            r_tsum    <= '0;
            r_psum    <= '0;
            r_tavg    <= '0;
            r_pavg    <= '0;
        end else begin
            if (i_cmd.tgt_direct) begin
                r_target <= (r_maxp == '0) ? '0 : pwsp_pkg::FULL_SCALE;
            end else if (i_cmd.div_cap) begin
                r_target <= div_quot[TW-1:0];
            end
            if (i_cmd.avg_load) begin
                r_tavg <= tprod[TSH +: TW];
                r_pavg <= pprod[PSH +: ADC_BITS];
            end
            if (i_cmd.ring_wr) begin
                r_tsum <= r_tsum - TSUM_W'(t_old) + TSUM_W'(r_target);
                r_psum <= r_psum - PSUM_W'(p_old) + PSUM_W'(r_adc);
                if (r_k == LAST_IDX) begin
                    r_k       <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    // signed difference of the averages, deadband widens only while braked
    assign diff    = DIFF_W'(r_tavg) - DIFF_W'(r_pavg);
    assign mag     = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    assign tol_now = r_deadband ? DIFF_W'(r_tol) : '0;

    always_comb begin
        if (mag <= tol_now) begin
            drive_now = pwsp_pkg::DRIVE_BRAKE;
        end else if (diff[DIFF_W-1]) begin
            drive_now = pwsp_pkg::DRIVE_CCW;
        end else begin
            drive_now = pwsp_pkg::DRIVE_CW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= 1'b1;
        end else if (i_cmd.out_load) begin
            r_deadband <= (drive_now == pwsp_pkg::DRIVE_BRAKE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_drive    <= drive_now;
            r_out_tavg <= r_tavg;
            r_out_pavg <= r_pavg;
            r_out_w    <= r_last_w;
        end
    end

    assign o_stat.pulse_end  = r_pulse_end;
    assign o_stat.sample_due = r_sample;
    assign o_stat.tgt_direct = (r_w == r_maxp);
    assign o_stat.div_busy   = div_busy;

    assign o_drive            = r_drive;
    assign o_target_average   = r_out_tavg;
    assign o_position_average = r_out_pavg;
    assign o_measured_width   = r_out_w;

endmodule

FILE: rtl/pwsp_ctrl.sv
`timescale 1ns / 1ps
`include "pulse_width_servo_position_control_defines.svh"
// ----------------------------------------------------------------------------
// Servo position controller sequencer
// Steps one tick through timing, division, window update and output.
// ----------------------------------------------------------------------------
module pwsp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output pwsp_pkg::t_cmd  o_cmd,
    input  pwsp_pkg::t_stat i_stat
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PULSE  = 3'd1;
    localparam logic [2:0] S_TDIV   = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_UPD    = 3'd4;
    localparam logic [2:0] S_AVG    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]     r_state;
    logic [2:0]     n_state;
    logic           r_out_valid;
    logic           n_out_valid;
    pwsp_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                cmd.accept = i_valid;
                if (i_valid) begin
                    n_state = S_PULSE;
                end
            end
            S_PULSE: begin
                if (i_stat.pulse_end && !i_stat.tgt_direct) begin
                    cmd.div_start = 1'b1;
                    n_state       = S_TDIV;
                end else begin
                    cmd.tgt_direct = i_stat.pulse_end;
                    n_state        = i_stat.sample_due ? S_RD : S_OUT;
                end
            end
            S_TDIV: begin
                if (!i_stat.div_busy) begin
                    cmd.div_cap = 1'b1;
                    n_state     = i_stat.sample_due ? S_RD : S_OUT;
                end
            end
            S_RD: begin
                cmd.ring_rd = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                cmd.ring_wr = 1'b1;
                n_state     = S_AVG;
            end
            S_AVG: begin
                // scale both updated sums down to the window averages
                cmd.avg_load = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    `PWSP_ASSERT_NOW(a_start_idle, i_clk, i_rst_n, cmd.div_start, !i_stat.div_busy)
    `PWSP_ASSERT_NOW(a_cap_done, i_clk, i_rst_n, cmd.div_cap, !i_stat.div_busy)
    `PWSP_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, cmd.out_load, !r_out_valid || i_ready)
    `PWSP_ASSERT_NXT(a_rd_then_wr, i_clk, i_rst_n, cmd.ring_rd, r_state == S_UPD)
    `PWSP_ASSERT_NXT(a_accept_pulse, i_clk, i_rst_n, cmd.accept, r_state == S_PULSE)

endmodule

FILE: rtl/pulse_width_servo_position_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse-width servo position controller
// Times the command pulse, averages target and position over a sample
// window and drives a motor bridge toward the target with a deadband.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready): one beat per microsecond tick, carrying
// the command pin level and the potentiometer reading. Output channel
// (o_valid/i_ready): one beat per input beat with the drive command, both
// window averages and the last clamped pulse width. Config channel
// (i_cfg_valid/o_cfg_ready) is always ready; write only while idle.
// Each tick passes through the pulse timing step; when a pulse ends, a serial
// division of width*4096 by max_pulse_ticks (12 quotient bits, skipped when
// the width equals max_pulse_ticks) follows, and when a window sample is
// taken, a ring read, a ring write with sum update, and reciprocal scaling of
// both sums by WINDOW_LEN follow, before the output step. One tick is in
// flight at a time. The next beat is taken while a result still waits.
// Reset: registers return to defaults, sums and averages to zero, deadband
// on; the sample rings need no clearing pass (a wrap flag masks old data).
// Stall: a result holds on the outputs until taken; a finished tick waits in
// its last step, and no new beat is taken until that result is stored.
// ----------------------------------------------------------------------------
module pulse_width_servo_position_control #(
    parameter int WINDOW_LEN = pwsp_pkg::WINDOW_LEN_DEF,
    parameter int ADC_BITS   = pwsp_pkg::ADC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input ticks
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_pulse_level,
    input  logic [ADC_BITS-1:0]                 i_adc_sample,
    // results
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_drive,
    output logic [pwsp_pkg::TARGET_W-1:0]       o_target_average,
    output logic [ADC_BITS-1:0]                 o_position_average,
    output logic [pwsp_pkg::WIDTH_W-1:0]        o_measured_width,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pwsp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pwsp_pkg::WIDTH_W-1:0]        i_cfg_data
);

    pwsp_pkg::t_cmd  cmd;
    pwsp_pkg::t_stat stat;

    // registers accept a beat on every cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: one tick at a time through the datapath steps
    pwsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // datapath: pulse timer, rings, sums, divider, drive decision
    pwsp_dp #(
        .WINDOW_LEN (WINDOW_LEN),
        .ADC_BITS   (ADC_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_pulse_level      (i_pulse_level),
        .i_adc_sample       (i_adc_sample),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_drive            (o_drive),
        .o_target_average   (o_target_average),
        .o_position_average (o_position_average),
        .o_measured_width   (o_measured_width)
    );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo position controller testbench
// Drives command-pulse ticks with random content, bursts and stalls, tracks
// pulse timing, sample windows and the deadband drive decision in a local
// scoreboard, and compares every result beat field by field.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [1:0]  drive;
    logic [12:0] target_avg;
    logic [11:0] position_avg;
    logic [15:0] width;
} servo_result_t;

class servo_scoreboard;
    logic [11:0]   tol;
    logic [15:0]   max_ticks;
    logic [15:0]   interval;
    logic          prev_level;
    logic          pulse_on;
    logic          deadband;
    logic [15:0]   high_count;
    logic [15:0]   last_width;
    logic [12:0]   target;
    int unsigned   timer;
    logic [6:0]    slot;
    logic [11:0]   position_window [128];
    logic [12:0]   target_window [128];
    int unsigned   position_sum;
    int unsigned   target_sum;
    servo_result_t pending_cmds [$];
    int            errors;

    function new();
        tol          = pwsp_pkg::TOL_RESET;
        max_ticks    = pwsp_pkg::MAXP_RESET;
        interval     = pwsp_pkg::SINT_RESET;
        prev_level   = 1'b0;
        pulse_on     = 1'b0;
        deadband     = 1'b1;
        high_count   = '0;
        last_width   = '0;
        target       = '0;
        timer        = 0;
        slot         = '0;
        position_sum = 0;
        target_sum   = 0;
        errors       = 0;
        foreach (position_window[i]) begin
            position_window[i] = '0;
            target_window[i]   = '0;
        end
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
        case (idx)
            pwsp_pkg::REG_TOLERANCE:  tol       = data[11:0];
            pwsp_pkg::REG_MAX_PULSE:  max_ticks = data;
            pwsp_pkg::REG_SAMPLE_INT: interval  = data;
            default: ;
        endcase
    endfunction

    function void note_error(string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    // Advance the controller by one tick and return its drive result.
    function servo_result_t servo_step(logic level, logic [11:0] adc);
        servo_result_t r;
        int unsigned   w;
        int unsigned   q;
        int            diff;
        int            mag;
        int            limit;
        if (level && !prev_level && !pulse_on) begin
            pulse_on   = 1'b1;
            high_count = 16'd1;
        end else if (level && pulse_on) begin
            if (high_count != 16'hFFFF)
                high_count++;
        end else if (!level && pulse_on) begin
            w = high_count;
            if (w > max_ticks)
                w = max_ticks;
            last_width = w[15:0];
            q = (max_ticks == 0) ? 0 : (w * 4096) / max_ticks;
            target   = q[12:0];
            pulse_on = 1'b0;
        end
        prev_level = level;

        timer++;
        if (timer >= interval) begin
            timer = 0;
            position_sum -= position_window[slot];
            target_sum   -= target_window[slot];
            position_window[slot] = adc;
            target_window[slot]   = target;
            position_sum += adc;
            target_sum   += target;
            slot++;
        end

        q = target_sum >> 7;
        r.target_avg = q[12:0];
        q = position_sum >> 7;
        r.position_avg = q[11:0];
        diff  = int'(r.target_avg) - int'(r.position_avg);
        mag   = (diff < 0) ? -diff : diff;
        limit = deadband ? int'(tol) : 0;
        if (mag <= limit) begin
            r.drive  = pwsp_pkg::DRIVE_BRAKE;
            deadband = 1'b1;
        end else if (diff > 0) begin
            r.drive  = pwsp_pkg::DRIVE_CW;
            deadband = 1'b0;
        end else begin
            r.drive  = pwsp_pkg::DRIVE_CCW;
            deadband = 1'b0;
        end
        r.width = last_width;
        return r;
    endfunction

    function void note_tick(logic level, logic [11:0] adc);
        pending_cmds.push_back(servo_step(level, adc));
    endfunction

    function void check_result(servo_result_t got);
        servo_result_t want;
        if (pending_cmds.size() == 0) begin
            note_error($sformatf("result with nothing pending: drv=%0d tavg=%0d pavg=%0d w=%0d",
                                 got.drive, got.target_avg, got.position_avg, got.width));
            return;
        end
        want = pending_cmds.pop_front();
        if (got.drive !== want.drive || got.target_avg !== want.target_avg ||
            got.position_avg !== want.position_avg || got.width !== want.width)
            note_error($sformatf(
                "mismatch exp drv=%0d tavg=%0d pavg=%0d w=%0d got drv=%0d tavg=%0d pavg=%0d w=%0d",
                want.drive, want.target_avg, want.position_avg, want.width,
                got.drive, got.target_avg, got.position_avg, got.width));
    endfunction

    function void close_out();
        if (pending_cmds.size() != 0)
            note_error($sformatf("%0d results never arrived", pending_cmds.size()));
    endfunction
endclass

module tb;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [1:0] REG_UNUSED = 2'd3;
    // Cycles without any beat before the run is declared hung.
    localparam int QUIET_LIMIT = 3000;
    // Length of the long receiver hold-off.
    localparam int HOLD_CYCLES = 400;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_pulse_level;
    logic [11:0] i_adc_sample;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_drive;
    logic [12:0] o_target_average;
    logic [11:0] o_position_average;
    logic [15:0] o_measured_width;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    servo_scoreboard sb;
    int              hold_left;
    int              burst_left;
    int              pos_track;
    int              quiet;

    pulse_width_servo_position_control dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_pulse_level      (i_pulse_level),
        .i_adc_sample       (i_adc_sample),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_drive            (o_drive),
        .o_target_average   (o_target_average),
        .o_position_average (o_position_average),
        .o_measured_width   (o_measured_width),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Sample result beats at the rising edge and run the hang watchdog.
    // Any beat on any channel resets the quiet count.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_drive, o_target_average, o_position_average, o_measured_width});
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: switch between random stall patterns.
    // A requested hold-off overrides the pattern and is counted down here.
    initial begin : receiver
        rx_mode_e rx_mode;
        int       mode_left;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:  i_ready <= 1'b1;
                    RX_LIGHT: i_ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: i_ready <= ($urandom_range(0, 3) == 0);
                    default:  i_ready <= ((mode_left % 8) < 3);
                endcase
            end
        end
    end

    // Offer one tick beat; hold it until accepted, then log the expectation.
    // Bursts of back-to-back beats alternate with random idle gaps.
    task automatic send_tick(input logic level, input logic [11:0] adc);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_pulse_level <= level;
        i_adc_sample  <= adc;
        do @(posedge i_clk); while (!o_ready);
        sb.note_tick(level, adc);
    endtask

    // Drop valid and hold off until every expected result has come back.
    task automatic drain_results;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    // Write one register; valid stays up so back-to-back writes chain.
    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic cfg_done;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed pulse trains with a drifting pot reading, plus
    // short stretches of glitchy levels and fully random readings.
    // Stop exactly at the requested tick count.
    task automatic run_random(input int n_items, input int span);
        int          sent;
        int          lo_len;
        int          hi_len;
        logic [11:0] adc;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 85) begin
                lo_len = $urandom_range(1, span);
                hi_len = $urandom_range(1, span + span / 2);
                for (int k = 0; k < lo_len + hi_len && sent < n_items; k++) begin
                    if ($urandom_range(0, 63) == 0)
                        pos_track = $urandom_range(0, 4095);
                    pos_track = pos_track + int'($urandom_range(0, 64)) - 32;
                    if (pos_track < 0)
                        pos_track = 0;
                    if (pos_track > 4095)
                        pos_track = 4095;
                    adc = pos_track[11:0];
                    send_tick(k >= lo_len, adc);
                    sent++;
                end
            end else begin
                lo_len = $urandom_range(1, 12);
                for (int k = 0; k < lo_len && sent < n_items; k++) begin
                    send_tick(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [15:0] tol_val;
        logic [15:0] max_val;
        logic [15:0] int_val;
        int          span;

        sb            = new();
        hold_left     = 0;
        burst_left    = 0;
        pos_track     = 2048;
        quiet         = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_pulse_level = 1'b0;
        i_adc_sample  = '0;
        i_ready       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = pwsp_pkg::REG_TOLERANCE;
        i_cfg_data    = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: reading extremes and a short 3-tick pulse.
        send_tick(1'b0, 12'd0);
        send_tick(1'b0, 12'hFFF);
        send_tick(1'b1, 12'hAAA);
        send_tick(1'b1, 12'h555);
        send_tick(1'b1, 12'hFFF);
        send_tick(1'b0, 12'd0);

        // Zero full-scale width, sample every tick, tolerance with junk
        // upper bits that must be masked off.
        drain_results();
        write_cfg(pwsp_pkg::REG_MAX_PULSE, 16'd0);
        write_cfg(pwsp_pkg::REG_SAMPLE_INT, 16'd0);
        write_cfg(pwsp_pkg::REG_TOLERANCE, 16'hFFFF);
        cfg_done();
        send_tick(1'b1, 12'hFFF);
        send_tick(1'b1, 12'hFFF);
        send_tick(1'b0, 12'hFFF);
        send_tick(1'b0, 12'd0);
        send_tick(1'b1, 12'h800);
        send_tick(1'b0, 12'd100);

        // Width clamping against a tiny full scale, a single-tick pulse,
        // zero tolerance and a write to the unmapped index.
        drain_results();
        write_cfg(pwsp_pkg::REG_TOLERANCE, 16'hF000);
        write_cfg(pwsp_pkg::REG_MAX_PULSE, 16'd5);
        write_cfg(pwsp_pkg::REG_SAMPLE_INT, 16'd1);
        write_cfg(REG_UNUSED, 16'h1234);
        cfg_done();
        for (int k = 0; k < 8; k++)
            send_tick(1'b1, 12'hFFF);
        send_tick(1'b0, 12'hFFF);
        send_tick(1'b1, 12'd0);
        send_tick(1'b0, 12'd0);
        send_tick(1'b0, 12'h7FF);

        // Random phases, each under its own register setting. Draining
        // before each write keeps the block idle while it is reconfigured.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    tol_val = 16'd0;
                    max_val = 16'd1;
                    int_val = 16'd1;
                end
                1: begin
                    tol_val = 16'hFFFF;
                    max_val = 16'hFFFF;
                    int_val = 16'd2;
                end
                3: begin
                    tol_val = 16'($urandom_range(0, 80));
                    max_val = 16'($urandom_range(20, 200));
                    int_val = 16'hFFFF;
                end
                default: begin
                    tol_val = 16'($urandom_range(0, 80));
                    max_val = 16'($urandom_range(2, 250));
                    int_val = 16'($urandom_range(1, 6));
                end
            endcase
            drain_results();
            write_cfg(pwsp_pkg::REG_TOLERANCE, tol_val);
            write_cfg(pwsp_pkg::REG_MAX_PULSE, max_val);
            write_cfg(pwsp_pkg::REG_SAMPLE_INT, int_val);
            cfg_done();
            // Starve the output for a long stretch while ticks keep coming.
            if (ph == 2)
                hold_left = HOLD_CYCLES;
            span = (max_val > 250) ? 250 : ((max_val < 2) ? 2 : int'(max_val));
            run_random(178, span);
        end

        // Wait out the last results plus the worst-case pipeline latency.
        drain_results();
        repeat (60) @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
